/* sv/pidarr_pkg.sv */
// shared types, codes and constants for the positional insert/delete array
package pidarr_pkg;

  localparam int unsigned DEPTH_DEF = 128;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned FILL_W    = 8;
  localparam int unsigned GRP_SIZE  = 32;

  localparam logic [REQ_W-1:0] REQ_READ   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef logic [2:0] cell_op_t;

  localparam cell_op_t CELL_HOLD = 3'd0;
  localparam cell_op_t CELL_INS  = 3'd1;
  localparam cell_op_t CELL_DEL  = 3'd2;
  localparam cell_op_t CELL_READ = 3'd3;
  localparam cell_op_t CELL_CLR  = 3'd4;

  typedef struct packed {
    cell_op_t          op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

/* sv/positional_insert_delete_array.sv */
// top level: request decode, fill count, cell chain and read-out reduction
//
// Ordered store of up to DEPTH signed 32-bit elements held in a chain of cells.
// Each transaction is a read, an insert or a delete at a zero-based position and
// returns one result with a status, the fill count after the request and, for a
// successful read, the element. Inserts and deletes shift every cell at once in
// the cycle the request is accepted. A new request is accepted only after the
// previous result has left the final stage of the reduction: the read data passes a
// cell register, a registered or over groups of 32 cells and a final registered or
// across the groups. A result waiting on out_ready does not block the next
// request, but that request's result waits in its last stage until the output
// register is free. The store needs no clearing after reset.
module positional_insert_delete_array import pidarr_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_new_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [FILL_W-1:0]        out_fill_count
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned NGRP  = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_GRP  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [STAT_W-1:0] out_status_r;
  logic [FILL_W-1:0] out_fill_r;
  logic              out_valid_r, out_valid_nxt;

  logic              accept;
  logic              fin_load;
  cell_op_t          op_dec;
  cell_ctl_t         ctl;
  logic [CMP_W-1:0]  pos_w;
  logic [CMP_W-1:0]  cnt_w;
  logic              empty;
  logic              full;

  logic [DATA_W-1:0] cell_val [DEPTH];
  logic [DATA_W-1:0] rd_pad   [NGRP][GRP_SIZE];
  logic [DATA_W-1:0] grp_or   [NGRP];
  logic [DATA_W-1:0] final_or;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fin_load = (state_r == S_FIN) && (!out_valid_r || out_ready);

  assign pos_w = CMP_W'(in_position);
  assign cnt_w = CMP_W'(cnt_r);
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_W'(DEPTH));

  // request decode
  always_comb begin
    op_dec   = CELL_CLR;
    stat_nxt = ST_OK;
    cnt_nxt  = cnt_r;
    unique case (in_req_type)
      REQ_READ: begin
        if (empty) begin
          stat_nxt = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          stat_nxt = ST_RANGE;
        end else begin
          op_dec = CELL_READ;
        end
      end
      REQ_INSERT: begin
        if (full) begin
          stat_nxt = ST_FULL;
        end else if (pos_w > cnt_w) begin
          stat_nxt = ST_RANGE;
        end else begin
          op_dec  = CELL_INS;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      REQ_DELETE: begin
        if (empty) begin
          stat_nxt = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          stat_nxt = ST_RANGE;
        end else begin
          op_dec  = CELL_DEL;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctl.op    = accept ? op_dec : CELL_HOLD;
  assign ctl.pos   = in_position;
  assign ctl.value = in_new_value;

  // cell chain
  for (genvar i = 0; i < int'(DEPTH); i++) begin : g_cell
    logic [DATA_W-1:0] left_v;
    logic [DATA_W-1:0] right_v;
    logic [DATA_W-1:0] rd_v;

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_left
      assign left_v = cell_val[i-1];
    end

    if (i == int'(DEPTH) - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_right
      assign right_v = cell_val[i+1];
    end

    pidarr_cell #(
      .IDX(i)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .left_i (left_v),
      .right_i(right_v),
      .val_o  (cell_val[i]),
      .rd_o   (rd_v)
    );

    assign rd_pad[i / GRP_SIZE][i % GRP_SIZE] = rd_v;
  end

  for (genvar j = int'(DEPTH); j < int'(NGRP * GRP_SIZE); j++) begin : g_pad
    assign rd_pad[j / GRP_SIZE][j % GRP_SIZE] = '0;
  end

  // read-out reduction
  for (genvar g = 0; g < int'(NGRP); g++) begin : g_grp
    pidarr_or_tree #(
      .N(GRP_SIZE)
    ) u_grp (
      .clk   (clk),
      .en    (state_r == S_GRP),
      .data_i(rd_pad[g]),
      .or_o  (grp_or[g])
    );
  end

  pidarr_or_tree #(
    .N(NGRP)
  ) u_final (
    .clk   (clk),
    .en    (fin_load),
    .data_i(grp_or),
    .or_o  (final_or)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_GRP;
      S_GRP:   state_nxt = S_FIN;
      S_FIN:   if (fin_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fin_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stat_r <= stat_nxt;
      fill_r <= FILL_W'(cnt_nxt);
    end
    if (fin_load) begin
      out_status_r <= stat_r;
      out_fill_r   <= fill_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;
  assign out_read_value = final_or;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(cnt_r))
    else $error("fill count changed without a transaction");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_GRP) ##1 (state_r == S_FIN))
    else $error("request did not advance through reduction");

  a_rose_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result valid without final stage");

  a_zero_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_read_value == '0)
    else $error("nonzero read value on refused request");

endmodule

/* sv/pidarr_cell.sv */
// one storage cell of the chain: shifts with its neighbors and offers its value for reads
module pidarr_cell import pidarr_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] val_o,
  output logic [DATA_W-1:0] rd_o
);

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] rd_r;
  logic              at_pos;
  logic              above_pos;

  assign at_pos    = (IDX == int'(ctl.pos));
  assign above_pos = (IDX > int'(ctl.pos));

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_INS: begin
        if (at_pos) begin
          val_r <= ctl.value;
        end else if (above_pos) begin
          val_r <= left_i;
        end
      end
      CELL_DEL: begin
        if (at_pos || above_pos) begin
          val_r <= right_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.op != CELL_HOLD) begin
      rd_r <= (ctl.op == CELL_READ && at_pos) ? val_r : '0;
    end
  end

  assign val_o = val_r;
  assign rd_o  = rd_r;

endmodule

/* sv/pidarr_or_tree.sv */
// registered or-reduction of a group of masked read values
module pidarr_or_tree import pidarr_pkg::*; #(
  parameter int unsigned N = GRP_SIZE
) (
  input  logic              clk,
  input  logic              en,
  input  logic [DATA_W-1:0] data_i [N],
  output logic [DATA_W-1:0] or_o
);

  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] or_r;

  always_comb begin
    acc = '0;
    for (int k = 0; k < int'(N); k++) begin
      acc = acc | data_i[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      or_r <= acc;
    end
  end

  assign or_o = or_r;

endmodule

/* sim/positional_insert_delete_array_tb.sv */
`timescale 1ns / 1ps
// testbench for the positional insert/delete array: scoreboard, directed and random traffic
module positional_insert_delete_array_tb;
  import pidarr_pkg::*;

  localparam int unsigned DEPTH        = DEPTH_DEF;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] value;
    logic [FILL_W-1:0]        fill;
  } array_result_t;

  class array_scoreboard;
    logic signed [DATA_W-1:0] cells [DEPTH];
    int unsigned fill;
    array_result_t expected_q[$];
    int unsigned errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      errors++;
    endtask

    function void note_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val);
      array_result_t res;
      res.status = ST_OK;
      res.value  = '0;
      case (req)
        REQ_READ: begin
          if (fill == 0) res.status = ST_EMPTY;
          else if (pos >= fill) res.status = ST_RANGE;
          else res.value = cells[pos];
        end
        REQ_INSERT: begin
          if (fill >= DEPTH) res.status = ST_FULL;
          else if (pos > fill) res.status = ST_RANGE;
          else begin
            for (int i = fill; i > pos; i--) cells[i] = cells[i - 1];
            cells[pos] = val;
            fill++;
          end
        end
        REQ_DELETE: begin
          if (fill == 0) res.status = ST_EMPTY;
          else if (pos >= fill) res.status = ST_RANGE;
          else begin
            for (int i = pos; i + 1 < fill; i++) cells[i] = cells[i + 1];
            fill--;
          end
        end
        default: ;
      endcase
      res.fill = fill[FILL_W-1:0];
      expected_q.push_back(res);
    endfunction

    task check_result(logic [STAT_W-1:0] status, logic signed [DATA_W-1:0] value,
                      logic [FILL_W-1:0] cnt);
      array_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending, status %0d", status));
        return;
      end
      want = expected_q.pop_front();
      if (status !== want.status)
        report($sformatf("status %0d, want %0d", status, want.status));
      if (value !== want.value)
        report($sformatf("read value %0d, want %0d", value, want.value));
      if (cnt !== want.fill)
        report($sformatf("fill count %0d, want %0d", cnt, want.fill));
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [REQ_W-1:0]         in_req_type = REQ_READ;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [DATA_W-1:0] in_new_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_read_value;
  logic [FILL_W-1:0]        out_fill_count;

  bit steady = 1'b0;
  int unsigned stall_cycles = 0;
  array_scoreboard board = new();

  positional_insert_delete_array #(.DEPTH(DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_new_value   (in_new_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_fill_count (out_fill_count)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_status, out_read_value, out_fill_count);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                              logic signed [DATA_W-1:0] val);
    while (!steady && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_position  <= pos;
    in_new_value <= val;
    do @(posedge clk); while (!in_ready);
    board.note_request(req, pos, val);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned mode, seg_left, f, lim, roll;
    logic [REQ_W-1:0] req;
    logic [POS_W-1:0] pos;
    logic signed [DATA_W-1:0] val;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty store, unused code, insert past the end
    send_request(REQ_READ, 8'd0, 32'sd0);
    send_request(REQ_DELETE, 8'd0, 32'sd0);
    send_request(REQ_NONE, 8'hff, 32'sh5a5a5a5a);
    send_request(REQ_INSERT, 8'd1, 32'sd1);
    // append, front and middle inserts with extreme values
    send_request(REQ_INSERT, 8'd0, 32'sh7fffffff);
    send_request(REQ_INSERT, 8'd1, 32'sh80000000);
    send_request(REQ_INSERT, 8'd0, -32'sd1);
    send_request(REQ_INSERT, 8'd2, 32'sd0);
    send_request(REQ_INSERT, 8'd4, 32'sh12345678);
    send_request(REQ_INSERT, 8'd6, 32'sd7);
    send_request(REQ_INSERT, 8'd128, 32'sd9);
    for (int i = 0; i < 5; i++) send_request(REQ_READ, i[POS_W-1:0], 32'sd0);
    send_request(REQ_READ, 8'd5, 32'sd0);
    send_request(REQ_READ, 8'hff, 32'sd0);
    // delete out of range, middle, front and last
    send_request(REQ_DELETE, 8'd5, 32'sd0);
    send_request(REQ_DELETE, 8'd2, 32'sd0);
    send_request(REQ_DELETE, 8'd0, 32'sd0);
    send_request(REQ_DELETE, 8'd2, 32'sd0);
    send_request(REQ_READ, 8'd0, 32'sd0);
    send_request(REQ_READ, 8'd1, 32'sd0);
    send_request(REQ_NONE, 8'd0, 32'sd0);

    // cycle through grow, mixed, shrink and mixed phases
    mode = 3;
    seg_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 500 && n < 800);
      if (n == 300 || n == 1000) wait_drained();
      if (seg_left == 0) begin
        mode = (mode + 1) % 4;
        seg_left = $urandom_range(240, 160);
      end
      seg_left--;
      f = board.fill;
      roll = $urandom_range(99);
      case (mode)
        0: req = (roll < 85) ? REQ_INSERT : (roll < 95) ? REQ_READ : REQ_DELETE;
        2: req = (roll < 85) ? REQ_DELETE : (roll < 95) ? REQ_READ : REQ_INSERT;
        default: req = (roll < 35) ? REQ_INSERT : (roll < 70) ? REQ_READ : REQ_DELETE;
      endcase
      lim = (req == REQ_INSERT) ? f : ((f == 0) ? 0 : f - 1);
      case ($urandom_range(3))
        0: pos = '0;
        1: pos = lim[POS_W-1:0];
        default: pos = POS_W'($urandom_range(lim));
      endcase
      if ($urandom_range(9) == 0) begin
        req = REQ_W'($urandom_range(3));
        pos = POS_W'($urandom_range(1) ? lim + 1 : $urandom_range(255));
      end
      case ($urandom_range(7))
        0: val = 32'sh7fffffff;
        1: val = 32'sh80000000;
        default: val = $urandom;
      endcase
      send_request(req, pos, val);
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (board.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
